/* rtl/core/snc_pkg.sv */
`default_nettype none

package snc_pkg;

	// cluster storage
	localparam int MAX_NEIGHBOURS = 16;
	localparam int IDX_W          = $clog2(MAX_NEIGHBOURS);
	localparam int CNT_W          = $clog2(MAX_NEIGHBOURS + 1);

	// compare pipeline registers that sit in the cluster ring
	localparam int PIPE_DEPTH     = 4;
	localparam int PASS_LEN       = MAX_NEIGHBOURS + PIPE_DEPTH;
	localparam int PASS_W         = $clog2(PASS_LEN);

	// field and arithmetic widths
	localparam int NRM_W          = 24;
	localparam int SUM_W          = 32;
	localparam int THR_W          = 16;
	localparam int NSQ_W          = 48;
	localparam int TSQ_W          = 32;
	localparam int Q_W            = 56;
	localparam int A_W            = 78;
	localparam int CA_W           = 64;
	localparam int DOT_W          = 57;
	localparam int DMAG_W         = 56;
	localparam int DLIMB_W        = 28;
	localparam int DPP_W          = 56;
	localparam int LHS_W          = 112;
	localparam int RHS_W          = 142;
	localparam int A_LIMB         = 26;
	localparam int A_LIMBS        = 3;
	localparam int CA_LIMB        = 32;
	localparam int CA_LIMBS       = 2;
	localparam int APP_W          = A_LIMB + CA_LIMB;
	localparam int LHS_SHIFT      = 30;

	localparam int ADDR_W         = 3;
	localparam logic [0:0] REG_THRESHOLD = 1'b0;
	localparam logic signed [THR_W-1:0] THR_RESET = 16'sd23170;

	typedef struct packed {
		logic signed [SUM_W-1:0] x;
		logic signed [SUM_W-1:0] y;
		logic signed [SUM_W-1:0] z;
	} cl_t;

	typedef struct packed {
		logic           advance;
		logic           vld;
		logic           na_zero;
		logic           thr_neg;
		logic [A_W-1:0] a_term;
	} snc_ctl_t;

	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] c,
		input logic signed [NRM_W-1:0] n
	);
		logic signed [SUM_W:0] s;
		s = {c[SUM_W-1], c} + {{(SUM_W+1-NRM_W){n[NRM_W-1]}}, n};
		if (s[SUM_W] != s[SUM_W-1]) begin
			sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sat_add = s[SUM_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/core/snc_cell.sv */
`default_nettype none

module snc_cell (
	input  wire              clk,
	input  wire              advance,
	input  wire              load,
	input  wire snc_pkg::cl_t shift_in,
	input  wire snc_pkg::cl_t load_val,
	output snc_pkg::cl_t     sum_out
);

	snc_pkg::cl_t sum_q;

	// one cluster sum, handed on to the neighbor on every ring step
	always_ff @(posedge clk) begin
		if (load) begin
			sum_q <= load_val;
		end else if (advance) begin
			sum_q <= shift_in;
		end
	end

	assign sum_out = sum_q;

endmodule

`default_nettype wire

/* rtl/core/snc_match.sv */
`default_nettype none

module snc_match (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire snc_pkg::snc_ctl_t             ctl,
	input  wire signed [snc_pkg::NRM_W-1:0]    nx,
	input  wire signed [snc_pkg::NRM_W-1:0]    ny,
	input  wire signed [snc_pkg::NRM_W-1:0]    nz,
	input  wire snc_pkg::cl_t                  ent_in,
	output snc_pkg::cl_t                       ent_out,
	output logic                               hit
);

	// stage 1: squares of the cluster and products with the normal
	logic [snc_pkg::SUM_W-1:0]        mx, my, mz;
	logic [snc_pkg::CA_W-1:0]         sqx_s1, sqy_s1, sqz_s1;
	logic signed [snc_pkg::DMAG_W-1:0] px_s1, py_s1, pz_s1;
	snc_pkg::cl_t                     cl_s1;
	logic                             vld_s1;

	assign mx = ent_in.x[snc_pkg::SUM_W-1] ? snc_pkg::SUM_W'(-ent_in.x) : ent_in.x;
	assign my = ent_in.y[snc_pkg::SUM_W-1] ? snc_pkg::SUM_W'(-ent_in.y) : ent_in.y;
	assign mz = ent_in.z[snc_pkg::SUM_W-1] ? snc_pkg::SUM_W'(-ent_in.z) : ent_in.z;

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			sqx_s1 <= mx * mx;
			sqy_s1 <= my * my;
			sqz_s1 <= mz * mz;
			px_s1  <= nx * ent_in.x;
			py_s1  <= ny * ent_in.y;
			pz_s1  <= nz * ent_in.z;
			cl_s1  <= ent_in;
		end
	end

	// stage 2: cluster length squared and dot product
	logic signed [snc_pkg::DOT_W-1:0] dot;
	logic [snc_pkg::CA_W-1:0]         ca_s2;
	logic [snc_pkg::DMAG_W-1:0]       dmag_s2;
	logic                             dneg_s2, dpos_s2, vld_s2;
	snc_pkg::cl_t                     cl_s2;

	assign dot = {px_s1[snc_pkg::DMAG_W-1], px_s1} + {py_s1[snc_pkg::DMAG_W-1], py_s1}
		+ {pz_s1[snc_pkg::DMAG_W-1], pz_s1};

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			ca_s2   <= sqx_s1 + sqy_s1 + sqz_s1;
			dmag_s2 <= dot[snc_pkg::DOT_W-1] ? snc_pkg::DMAG_W'(-dot) : dot[snc_pkg::DMAG_W-1:0];
			dneg_s2 <= dot[snc_pkg::DOT_W-1];
			dpos_s2 <= !dot[snc_pkg::DOT_W-1] && (dot != '0);
			cl_s2   <= cl_s1;
		end
	end

	// stage 3: partial products of dot^2 and a_term * cluster length
	logic [snc_pkg::DLIMB_W-1:0] dl, dh;
	logic [snc_pkg::DPP_W-1:0]   pll_s3, plh_s3, phh_s3;
	logic [snc_pkg::APP_W-1:0]   pr_s3 [snc_pkg::A_LIMBS][snc_pkg::CA_LIMBS];
	logic                        cz_s3, dneg_s3, dpos_s3, vld_s3;
	snc_pkg::cl_t                cl_s3;

	assign dl = dmag_s2[snc_pkg::DLIMB_W-1:0];
	assign dh = dmag_s2[snc_pkg::DMAG_W-1:snc_pkg::DLIMB_W];

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			pll_s3 <= dl * dl;
			plh_s3 <= dl * dh;
			phh_s3 <= dh * dh;
			for (int i = 0; i < snc_pkg::A_LIMBS; i++) begin
				for (int j = 0; j < snc_pkg::CA_LIMBS; j++) begin
					pr_s3[i][j] <= ctl.a_term[i*snc_pkg::A_LIMB +: snc_pkg::A_LIMB]
						* ca_s2[j*snc_pkg::CA_LIMB +: snc_pkg::CA_LIMB];
				end
			end
			cz_s3   <= (ca_s2 == '0);
			dneg_s3 <= dneg_s2;
			dpos_s3 <= dpos_s2;
			cl_s3   <= cl_s2;
		end
	end

	// stage 4: both sides of the cosine test
	logic [snc_pkg::RHS_W-1:0] rhs_sum;
	logic [snc_pkg::LHS_W-1:0] lhs_s4;
	logic [snc_pkg::RHS_W-1:0] rhs_s4;
	logic                      cz_s4, dneg_s4, dpos_s4, vld_s4;
	snc_pkg::cl_t              cl_s4;

	always_comb begin
		rhs_sum = '0;
		for (int i = 0; i < snc_pkg::A_LIMBS; i++) begin
			for (int j = 0; j < snc_pkg::CA_LIMBS; j++) begin
				rhs_sum = rhs_sum + (snc_pkg::RHS_W'(pr_s3[i][j])
					<< (i*snc_pkg::A_LIMB + j*snc_pkg::CA_LIMB));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			lhs_s4  <= (snc_pkg::LHS_W'(phh_s3) << (2*snc_pkg::DLIMB_W))
				+ (snc_pkg::LHS_W'(plh_s3) << (snc_pkg::DLIMB_W + 1))
				+ snc_pkg::LHS_W'(pll_s3);
			rhs_s4  <= rhs_sum;
			cz_s4   <= cz_s3;
			dneg_s4 <= dneg_s3;
			dpos_s4 <= dpos_s3;
			cl_s4   <= cl_s3;
		end
	end

	// entry validity flags are control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (ctl.advance) begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// final compare and saturating update
	logic [snc_pkg::RHS_W-1:0] lhs_w;
	logic                      gt, lt;

	assign lhs_w = {lhs_s4, {snc_pkg::LHS_SHIFT{1'b0}}};
	assign gt    = lhs_w > rhs_s4;
	assign lt    = lhs_w < rhs_s4;

	assign hit = vld_s4 && !ctl.na_zero && !cz_s4
		&& (ctl.thr_neg ? (dneg_s4 ? lt : 1'b1) : (dpos_s4 && gt));

	always_comb begin
		ent_out = cl_s4;
		if (hit) begin
			ent_out.x = snc_pkg::sat_add(cl_s4.x, nx);
			ent_out.y = snc_pkg::sat_add(cl_s4.y, ny);
			ent_out.z = snc_pkg::sat_add(cl_s4.z, nz);
		end
	end

endmodule

`default_nettype wire

/* rtl/core/surface_normal_cluster_classifier.sv */
// surface normal cluster classifier
//
// s_* channel: one face normal per request, tdata = {z, y, x} (24 bits each,
// signed), tlast marks the final normal of a mesh node. m_* channel: one
// result per node, sent for the request that carried tlast.
// apb port: register 0 (byte address 0) is the cosine threshold, Q1.15.
//
// every request passes through the accept state, four setup states for normal
// length and threshold, then one full turn of the cluster ring (MAX_NEIGHBOURS
// cells plus the four compare pipeline registers), then one state to open a new
// cluster and close the node. s_tready is high only between requests, so a new
// normal is not taken before the last one is through. the node result enters
// m_tdata as the node closes, or later from a hold state once it is free.
// a result sits in the m_tdata register until taken; the next normal is
// accepted meanwhile, and only a second node end waits for the register.
// reset clears the cluster count, the pending result and the threshold
// (back to 23170); cluster sums hold no reset and are read only once written.
`default_nettype none

module surface_normal_cluster_classifier (
	input  wire                        clk,
	input  wire                        arst_n,
	// configuration
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire [snc_pkg::ADDR_W-1:0]  paddr,
	input  wire [31:0]                 pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	// normals in
	input  wire                        s_tvalid,
	output logic                       s_tready,
	input  wire [71:0]                 s_tdata,   // normal_x, normal_y, normal_z
	input  wire                        s_tlast,   // last_normal
	// classification out
	output logic                       m_tvalid,
	input  wire                        m_tready,
	output logic [7:0]                 m_tdata    // surface_class, cluster_total, pad
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP1 = 3'd1;
	localparam logic [2:0] ST_PREP2 = 3'd2;
	localparam logic [2:0] ST_PREP3 = 3'd3;
	localparam logic [2:0] ST_PREP4 = 3'd4;
	localparam logic [2:0] ST_RUN   = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;
	localparam logic [2:0] ST_HOLD  = 3'd7;

	localparam int NW = snc_pkg::NRM_W;

	logic [2:0]                          state_q;
	logic signed [snc_pkg::THR_W-1:0]    thr_q;
	logic signed [NW-1:0]                nx_q, ny_q, nz_q;
	logic                                last_q;
	logic [snc_pkg::NSQ_W-1:0]           sqx_q, sqy_q, sqz_q, na_q;
	logic [snc_pkg::TSQ_W-1:0]           tsq_q;
	logic [snc_pkg::Q_W-1:0]             q0_q, q1_q;
	logic [snc_pkg::A_W-1:0]             a_q;
	logic [snc_pkg::PASS_W-1:0]          k_q;
	logic [snc_pkg::CNT_W-1:0]           count_q;
	logic                                joined_q;
	logic                                m_tvalid_q;
	logic [7:0]                          m_tdata_q;

	// apb register port
	logic wr_en;
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready
		&& (paddr[snc_pkg::ADDR_W-1:2] == snc_pkg::REG_THRESHOLD);

	always_comb begin
		prdata = '0;
		if (paddr[snc_pkg::ADDR_W-1:2] == snc_pkg::REG_THRESHOLD) begin
			prdata = {{(32-snc_pkg::THR_W){thr_q[snc_pkg::THR_W-1]}}, thr_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= snc_pkg::THR_RESET;
		end else if (wr_en) begin
			thr_q <= pwdata[snc_pkg::THR_W-1:0];
		end
	end

	// magnitudes for the setup squares
	logic [NW-1:0]            mnx, mny, mnz;
	logic [snc_pkg::THR_W-1:0] mthr;
	assign mnx  = nx_q[NW-1] ? NW'(-nx_q) : nx_q;
	assign mny  = ny_q[NW-1] ? NW'(-ny_q) : ny_q;
	assign mnz  = nz_q[NW-1] ? NW'(-nz_q) : nz_q;
	assign mthr = thr_q[snc_pkg::THR_W-1] ? snc_pkg::THR_W'(-thr_q) : thr_q;

	// cluster ring
	snc_pkg::snc_ctl_t ctl;
	snc_pkg::cl_t      cell_out [snc_pkg::MAX_NEIGHBOURS];
	snc_pkg::cl_t      match_out;
	snc_pkg::cl_t      ins_val;
	logic              hit;
	logic              advance;
	logic              load_en;
	logic [snc_pkg::CNT_W-1:0] count_next;
	logic              out_free;
	logic              res_load;

	assign advance = (state_q == ST_RUN);
	assign load_en = (state_q == ST_FIN) && !joined_q
		&& (32'(count_q) < snc_pkg::MAX_NEIGHBOURS);
	assign count_next = load_en ? count_q + 1'b1 : count_q;
	assign out_free   = !m_tvalid_q || m_tready;
	// a node result enters the output register
	assign res_load   = out_free
		&& (((state_q == ST_FIN) && last_q) || (state_q == ST_HOLD));

	assign ins_val.x = {{(snc_pkg::SUM_W-NW){nx_q[NW-1]}}, nx_q};
	assign ins_val.y = {{(snc_pkg::SUM_W-NW){ny_q[NW-1]}}, ny_q};
	assign ins_val.z = {{(snc_pkg::SUM_W-NW){nz_q[NW-1]}}, nz_q};

	assign ctl.advance = advance;
	assign ctl.vld     = advance && (32'(k_q) < 32'(count_q));
	assign ctl.na_zero = (na_q == '0);
	assign ctl.thr_neg = thr_q[snc_pkg::THR_W-1];
	assign ctl.a_term  = a_q;

	for (genvar i = 0; i < snc_pkg::MAX_NEIGHBOURS; i++) begin : g_cell
		snc_pkg::cl_t nb;
		if (i == snc_pkg::MAX_NEIGHBOURS - 1) begin : g_tail
			assign nb = match_out;
		end else begin : g_body
			assign nb = cell_out[i+1];
		end
		snc_cell u_cell (
			.clk      (clk),
			.advance  (advance),
			.load     (load_en && (count_q[snc_pkg::IDX_W-1:0] == snc_pkg::IDX_W'(i))),
			.shift_in (nb),
			.load_val (ins_val),
			.sum_out  (cell_out[i])
		);
	end

	snc_match u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.nx      (nx_q),
		.ny      (ny_q),
		.nz      (nz_q),
		.ent_in  (cell_out[0]),
		.ent_out (match_out),
		.hit     (hit)
	);

	// setup datapath: |n|^2 and threshold^2 * |n|^2
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			nx_q   <= s_tdata[NW-1:0];
			ny_q   <= s_tdata[2*NW-1:NW];
			nz_q   <= s_tdata[3*NW-1:2*NW];
			last_q <= s_tlast;
		end
		if (state_q == ST_PREP1) begin
			sqx_q <= mnx * mnx;
			sqy_q <= mny * mny;
			sqz_q <= mnz * mnz;
			tsq_q <= mthr * mthr;
		end
		if (state_q == ST_PREP2) begin
			na_q <= sqx_q + sqy_q + sqz_q;
		end
		if (state_q == ST_PREP3) begin
			q0_q <= tsq_q * na_q[NW-1:0];
			q1_q <= tsq_q * na_q[2*NW-1:NW];
		end
		if (state_q == ST_PREP4) begin
			a_q <= snc_pkg::A_W'(q0_q) + (snc_pkg::A_W'(q1_q) << NW);
		end
	end

	// result valid flag: set on a node result, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// sequencer, cluster count and result data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			k_q        <= '0;
			count_q    <= '0;
			joined_q   <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_PREP1;
					end
				end
				ST_PREP1: state_q <= ST_PREP2;
				ST_PREP2: state_q <= ST_PREP3;
				ST_PREP3: state_q <= ST_PREP4;
				ST_PREP4: begin
					k_q      <= '0;
					joined_q <= 1'b0;
					state_q  <= ST_RUN;
				end
				ST_RUN: begin
					joined_q <= joined_q | hit;
					k_q      <= k_q + 1'b1;
					if (32'(k_q) == snc_pkg::PASS_LEN - 1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!last_q) begin
						count_q <= count_next;
						state_q <= ST_IDLE;
					end else if (out_free) begin
						m_tdata_q  <= {1'b0, count_next,
							(count_next >= 3) ? 2'd3 : count_next[1:0]};
						count_q    <= '0;
						state_q    <= ST_IDLE;
					end else begin
						count_q <= count_next;
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						m_tdata_q  <= {1'b0, count_q,
							(count_q >= 3) ? 2'd3 : count_q[1:0]};
						count_q    <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// cluster count never passes the ring size
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= snc_pkg::MAX_NEIGHBOURS)
		else $error("cluster count overflow");

	// a match can only come out of the ring while it turns
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) |-> !hit)
		else $error("match outside ring pass");

	// a new result only follows the closing of a node
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_FIN || $past(state_q) == ST_HOLD))
		else $error("result without node end");

endmodule

`default_nettype wire

/* tb/sv/surface_normal_cluster_classifier_tb.sv */
`timescale 1ns / 1ps

module surface_normal_cluster_classifier_tb;

	localparam int CLUSTER_CAP = snc_pkg::MAX_NEIGHBOURS;

	typedef struct {
		logic signed [snc_pkg::NRM_W-1:0] nx;
		logic signed [snc_pkg::NRM_W-1:0] ny;
		logic signed [snc_pkg::NRM_W-1:0] nz;
		logic                             last;
	} normal_req_t;

	typedef struct {
		logic [1:0] cls;
		logic [4:0] total;
	} class_res_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [snc_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid;
	logic s_tready;
	logic [71:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [7:0] m_tdata;

	surface_normal_cluster_classifier dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// predictor state: cluster sums, open count and the threshold
	logic signed [snc_pkg::SUM_W-1:0] sum_x [CLUSTER_CAP];
	logic signed [snc_pkg::SUM_W-1:0] sum_y [CLUSTER_CAP];
	logic signed [snc_pkg::SUM_W-1:0] sum_z [CLUSTER_CAP];
	int unsigned open_clusters;
	logic signed [snc_pkg::THR_W-1:0] cos_thr;

	normal_req_t pending_normals[$];
	class_res_t  expected_classes[$];
	int errors;
	bit no_idle;
	bit hold_send;

	function automatic logic signed [snc_pkg::SUM_W-1:0] clamp_add(
			logic signed [snc_pkg::SUM_W-1:0] c, logic signed [snc_pkg::NRM_W-1:0] n);
		longint s;
		s = longint'(c) + longint'(n);
		if (s > 64'sd2147483647) return 32'sh7fffffff;
		if (s < -64'sd2147483648) return 32'sh80000000;
		return s[snc_pkg::SUM_W-1:0];
	endfunction

	// exact angle test: dot^2 * 2^30 against t^2 * |n|^2 * |c|^2 with sign handling
	function automatic bit joins_cluster(normal_req_t r, int k);
		logic signed [63:0] cx, cy, cz, nx, ny, nz;
		logic signed [127:0] dot;
		logic [127:0] na, ca, dmag;
		logic [255:0] lhs, rhs;
		logic [31:0] tm;
		cx = sum_x[k]; cy = sum_y[k]; cz = sum_z[k];
		nx = r.nx; ny = r.ny; nz = r.nz;
		na = 128'(nx * nx) + 128'(ny * ny) + 128'(nz * nz);
		ca = 128'(cx * cx) + 128'(cy * cy) + 128'(cz * cz);
		dot = 128'(nx * cx) + 128'(ny * cy) + 128'(nz * cz);
		if (na == 0 || ca == 0) return 0;
		if (cos_thr >= 0 && dot <= 0) return 0;
		if (cos_thr < 0 && dot >= 0) return 1;
		dmag = dot < 0 ? 128'(-dot) : 128'(dot);
		tm = cos_thr < 0 ? 32'(-int'(cos_thr)) : 32'(int'(cos_thr));
		lhs = (256'(dmag) * 256'(dmag)) << 30;
		rhs = 256'(tm * tm) * 256'(na) * 256'(ca);
		return cos_thr >= 0 ? lhs > rhs : lhs < rhs;
	endfunction

	// fold one normal into the clusters, queue the class on node end
	task automatic classify_normal(normal_req_t r);
		bit joined;
		class_res_t e;
		joined = 0;
		for (int k = 0; k < open_clusters; k++) begin
			if (joins_cluster(r, k)) begin
				sum_x[k] = clamp_add(sum_x[k], r.nx);
				sum_y[k] = clamp_add(sum_y[k], r.ny);
				sum_z[k] = clamp_add(sum_z[k], r.nz);
				joined = 1;
			end
		end
		if (!joined && open_clusters < CLUSTER_CAP) begin
			sum_x[open_clusters] = r.nx;
			sum_y[open_clusters] = r.ny;
			sum_z[open_clusters] = r.nz;
			open_clusters++;
		end
		if (r.last) begin
			e.cls = open_clusters >= 3 ? 2'd3 : 2'(open_clusters);
			e.total = 5'(open_clusters);
			expected_classes.insert(expected_classes.size(), e);
			open_clusters = 0;
		end
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// driver: idles about one cycle in ten unless no_idle is set, and sends nothing while hold_send is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
			s_tlast <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				normal_req_t done;
				done = pending_normals.pop_front();
				classify_normal(done);
			end
			if ((!s_tvalid || s_tready) && !hold_send) begin
				if (pending_normals.size() > 0 && (no_idle || $urandom_range(99) >= 10)) begin
					normal_req_t r;
					r = pending_normals[0];
					s_tvalid <= 1;
					s_tdata <= {r.nz, r.ny, r.nx};
					s_tlast <= r.last;
				end else begin
					s_tvalid <= 0;
				end
			end else if (hold_send && s_tvalid && s_tready) begin
				s_tvalid <= 0;
			end
		end
	end

	// monitor: random backpressure, checks each result against the oldest class
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			m_tready <= no_idle || $urandom_range(99) >= 10;
			if (m_tvalid && m_tready) begin
				if (expected_classes.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result class=%0d total=%0d",
							m_tdata[1:0], m_tdata[6:2]);
				end else begin
					class_res_t e;
					e = expected_classes.pop_front();
					if (m_tdata[1:0] !== e.cls || m_tdata[6:2] !== e.total) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected class=%0d total=%0d, %s%0d total=%0d",
								e.cls, e.total, "got class=", m_tdata[1:0], m_tdata[6:2]);
					end
				end
			end
		end
	end

	task automatic write_threshold(logic signed [snc_pkg::THR_W-1:0] t);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= snc_pkg::ADDR_W'(snc_pkg::REG_THRESHOLD) << 2; pwdata <= 32'(t);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		cos_thr = t;
	endtask

	// wait until all normals are sent and all classes have arrived, then let the block settle
	task automatic drain();
		while (pending_normals.size() > 0 || s_tvalid || expected_classes.size() > 0)
			@(posedge clk);
		repeat (3 * (snc_pkg::PASS_LEN + 10)) @(posedge clk);
	endtask

	function automatic logic signed [snc_pkg::NRM_W-1:0] rand_comp(int mode);
		case (mode)
			0: return snc_pkg::NRM_W'($urandom);
			1: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
			default: return snc_pkg::NRM_W'($urandom_range(2000)) - 24'sd1000;
		endcase
	endfunction

	task automatic push_normal(logic signed [snc_pkg::NRM_W-1:0] x, y, z, logic l);
		normal_req_t r;
		r.nx = x; r.ny = y; r.nz = z; r.last = l;
		pending_normals.insert(pending_normals.size(), r);
	endtask

	// one node: fams noisy direction families so clusters merge, or all random or all extreme normals
	task automatic push_node(int count, int fams);
		logic signed [snc_pkg::NRM_W-1:0] bx [4], by [4], bz [4];
		int f, mode;
		mode = $urandom_range(9);
		for (int i = 0; i < 4; i++) begin
			bx[i] = rand_comp(0) >>> 2; by[i] = rand_comp(0) >>> 2; bz[i] = rand_comp(0) >>> 2;
		end
		for (int i = 0; i < count; i++) begin
			f = $urandom_range(fams - 1);
			if (mode == 0)
				push_normal(rand_comp(0), rand_comp(0), rand_comp(0), i == count - 1);
			else if (mode == 1)
				push_normal(rand_comp(1), rand_comp(1), rand_comp(1), i == count - 1);
			else
				push_normal(bx[f] + rand_comp(2), by[f] + rand_comp(2),
					bz[f] + rand_comp(2), i == count - 1);
		end
	endtask

	int sent;

	initial begin
		logic signed [snc_pkg::THR_W-1:0] thr_list [5];
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		errors = 0; no_idle = 0; hold_send = 0;
		open_clusters = 0; cos_thr = snc_pkg::THR_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset threshold, zero vectors, extremes, saturation, full clusters
		push_normal(0, 0, 0, 1);
		push_normal(0, 0, 0, 0);
		push_normal(0, 0, 0, 1);
		push_normal(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 0);
		push_normal(24'sh800000, 24'sh800000, 24'sh800000, 0);
		push_normal(24'sh7fffff, 0, 0, 0);
		push_normal(0, 24'sh7fffff, 0, 1);
		for (int i = 0; i < 6; i++) push_normal(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 0);
		push_normal(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 1);
		for (int i = 0; i < 18; i++)
			push_normal(i % 2 ? 24'sh7fffff : 24'sh800000, 24'(i * 331), 24'(-i * 97), i == 17);
		drain();

		thr_list[0] = 16'sh7fff; thr_list[1] = 16'sh8000; thr_list[2] = 16'sd0;
		thr_list[3] = 16'sd28378; thr_list[4] = -16'sd16384;
		sent = 0;
		for (int ph = 0; ph < 6; ph++) begin
			write_threshold(ph < 5 ? thr_list[ph] : snc_pkg::THR_W'($urandom));
			no_idle = (ph == 2);
			while (sent < (ph + 1) * 290) begin
				int n;
				n = $urandom_range(9) == 0 ? $urandom_range(20, 17) : $urandom_range(6, 1);
				push_node(n, $urandom_range(4, 1));
				sent += n;
			end
			if (ph == 3) begin
				// sender holds midway until every expected class has arrived
				while (pending_normals.size() > 150) @(posedge clk);
				hold_send = 1;
				while (s_tvalid || expected_classes.size() > 0) @(posedge clk);
				repeat (snc_pkg::PASS_LEN + 10) @(posedge clk);
				hold_send = 0;
			end
			drain();
		end

		if (errors == 0) begin
			$display("surface_normal_cluster_classifier test passed");
		end else begin
			$display("surface_normal_cluster_classifier test failed");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("surface_normal_cluster_classifier test failed");
		$finish;
	end

endmodule

/* surface_normal_cluster_classifier.f */
rtl/core/snc_pkg.sv
rtl/core/snc_cell.sv
rtl/core/snc_match.sv
rtl/core/surface_normal_cluster_classifier.sv
tb/sv/surface_normal_cluster_classifier_tb.sv
